// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl folder
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/lsbse_pkg.sv =====
// types and constants for the lsb stego extractor
// no dependencies; imported by lsb_stego_extractor_unit
package lsbse_pkg;

    localparam int MAGIC_MAX_CHARS_DEF = 8;

    localparam logic [15:0] HEADER_SKIP_RESET  = 16'd54;
    localparam logic [63:0] MAGIC_WORD_RESET   = 64'd10787;
    localparam logic [3:0]  MAGIC_LENGTH_RESET = 4'd2;

    localparam logic [5:0] BYTE_BITS = 6'd8;
    localparam logic [5:0] SIZE_BITS = 6'd32;

    // configuration register indexes
    localparam logic [1:0] CFG_HEADER_SKIP  = 2'd0;
    localparam logic [1:0] CFG_MAGIC_WORD   = 2'd1;
    localparam logic [1:0] CFG_MAGIC_LENGTH = 2'd2;

    // request kinds
    localparam logic KIND_COVER   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_MAGIC     = 3'd1,
        PH_EXT_SIZE  = 3'd2,
        PH_EXT_BYTES = 3'd3,
        PH_PAY_SIZE  = 3'd4,
        PH_PAY_BYTES = 3'd5,
        PH_DONE      = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        RK_EXT_SIZE  = 3'd0,
        RK_EXT_BYTE  = 3'd1,
        RK_PAY_SIZE  = 3'd2,
        RK_PAY_BYTE  = 3'd3,
        RK_MISMATCH  = 3'd4
    } result_kind_t;

endpackage

// ===== rtl/lsb_stego_extractor_unit.sv =====
// lsb stego extractor top level: bit collection, magic check, size and byte output
// depends on lsbse_pkg and assert_macros.svh
//
// usage
// - item channel (item_valid/item_ready): one cover byte or a restart per request;
//   only bit 0 of cover_byte carries hidden data
// - result channel (result_valid/result_ready): result_kind, value, last
// - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): header_skip, magic_word,
//   magic_length; cfg_ready is always high, and writes are registered
// - each request is handled in one pass of logic; a result shows up in the
//   output register in the cycle after the request that completes it is accepted
// - throughput is one request per cycle while the receiver takes each result;
//   the single output register sets it: item_ready = !result_valid | result_ready
// - when the receiver stalls with a result held, item_ready drops until the
//   result is taken; no request is lost or repeated
// - reset loads the register defaults and returns decoding to the header phase;
//   a restart request does the same to decoding state but keeps the registers
`include "assert_macros.svh"

module lsb_stego_extractor_unit
    import lsbse_pkg::*;
#(
    parameter int MAGIC_MAX_CHARS = MAGIC_MAX_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic        kind,
    input  logic [7:0]  cover_byte,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  result_kind,
    output logic [31:0] value,
    output logic        last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int          MIDX_W  = $clog2(MAGIC_MAX_CHARS + 1);
    localparam logic [3:0]  MAX_LEN = 4'(MAGIC_MAX_CHARS);

    // configuration registers
    logic [15:0] header_skip_reg, header_skip_next;
    logic [63:0] magic_word_reg, magic_word_next;
    logic [3:0]  magic_length_reg, magic_length_next;

    // decoding state
    phase_t              phase_reg, phase_next;
    logic [15:0]         header_count_reg, header_count_next;
    logic [31:0]         bit_shift_reg, bit_shift_next;
    logic [5:0]          bit_count_reg, bit_count_next;
    logic [MIDX_W-1:0]   magic_index_reg, magic_index_next;
    logic [31:0]         bytes_rem_reg, bytes_rem_next;

    // output register
    logic                result_valid_reg, result_valid_next;
    result_kind_t        res_kind_reg, res_kind_next;
    logic [31:0]         res_value_reg, res_value_next;
    logic                res_last_reg, res_last_next;
    logic                res_fire;

    logic        step, restart, take;
    logic        header_wait, collecting, is_size, word_done, magic_ok, magic_end;
    phase_t      eff_phase;
    logic [3:0]  len_eff;
    logic [2:0]  magic_sel;
    logic [7:0]  magic_expect;
    logic [31:0] shift_in, word, rem_dec;
    logic [5:0]  count_inc;

    assign cfg_ready  = 1'b1;
    assign item_ready = !result_valid_reg || result_ready;
    assign step       = item_valid && item_ready;
    assign restart    = step && (kind == KIND_RESTART);
    assign take       = step && (kind == KIND_COVER);

    // configuration decode
    always_comb
    begin
        header_skip_next  = header_skip_reg;
        magic_word_next   = magic_word_reg;
        magic_length_next = magic_length_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HEADER_SKIP:  header_skip_next  = cfg_data[15:0];
                CFG_MAGIC_WORD:   magic_word_next   = cfg_data;
                CFG_MAGIC_LENGTH: magic_length_next = cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // shared datapath terms
    always_comb
    begin
        len_eff      = (magic_length_reg > MAX_LEN) ? MAX_LEN : magic_length_reg;
        header_wait  = (phase_reg == PH_HEADER) && (header_count_reg < header_skip_reg);
        if (phase_reg == PH_HEADER)
            eff_phase = (len_eff == 4'd0) ? PH_EXT_SIZE : PH_MAGIC;
        else
            eff_phase = phase_reg;
        collecting   = !header_wait && (eff_phase != PH_DONE);
        is_size      = (eff_phase == PH_EXT_SIZE) || (eff_phase == PH_PAY_SIZE);
        shift_in     = {bit_shift_reg[30:0], cover_byte[0]};
        count_inc    = bit_count_reg + 6'd1;
        word_done    = collecting && (count_inc == (is_size ? SIZE_BITS : BYTE_BITS));
        word         = is_size ? shift_in : {24'd0, shift_in[7:0]};
        magic_sel    = 3'(magic_index_reg);
        magic_expect = magic_word_reg[{magic_sel, 3'b000} +: 8];
        magic_ok     = (shift_in[7:0] == magic_expect);
        magic_end    = (4'(magic_index_reg) + 4'd1) >= len_eff;
        rem_dec      = bytes_rem_reg - 32'd1;
    end

    // next decoding state
    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        bit_shift_next    = bit_shift_reg;
        bit_count_next    = bit_count_reg;
        magic_index_next  = magic_index_reg;
        bytes_rem_next    = bytes_rem_reg;
        if (restart)
        begin
            phase_next        = PH_HEADER;
            header_count_next = '0;
            bit_shift_next    = '0;
            bit_count_next    = '0;
            magic_index_next  = '0;
            bytes_rem_next    = '0;
        end
        else if (take && header_wait)
        begin
            header_count_next = header_count_reg + 16'd1;
        end
        else if (take && collecting && !word_done)
        begin
            phase_next     = eff_phase;
            bit_shift_next = shift_in;
            bit_count_next = count_inc;
        end
        else if (take && word_done)
        begin
            bit_shift_next = '0;
            bit_count_next = '0;
            unique case (eff_phase)
                PH_MAGIC:
                begin
                    if (!magic_ok)
                        phase_next = PH_DONE;
                    else
                    begin
                        magic_index_next = magic_index_reg + MIDX_W'(1);
                        phase_next       = magic_end ? PH_EXT_SIZE : PH_MAGIC;
                    end
                end
                PH_EXT_SIZE:
                begin
                    bytes_rem_next = word;
                    phase_next     = (word == 32'd0) ? PH_PAY_SIZE : PH_EXT_BYTES;
                end
                PH_EXT_BYTES:
                begin
                    bytes_rem_next = rem_dec;
                    phase_next     = (rem_dec == 32'd0) ? PH_PAY_SIZE : PH_EXT_BYTES;
                end
                PH_PAY_SIZE:
                begin
                    bytes_rem_next = word;
                    phase_next     = (word == 32'd0) ? PH_DONE : PH_PAY_BYTES;
                end
                PH_PAY_BYTES:
                begin
                    bytes_rem_next = rem_dec;
                    phase_next     = (rem_dec == 32'd0) ? PH_DONE : PH_PAY_BYTES;
                end
                default: ;
            endcase
        end
    end

    // result for the current request
    always_comb
    begin
        res_fire      = take && word_done && !((eff_phase == PH_MAGIC) && magic_ok);
        res_kind_next = RK_EXT_SIZE;
        res_value_next = word;
        res_last_next = 1'b0;
        unique case (eff_phase)
            PH_MAGIC:
            begin
                res_kind_next  = RK_MISMATCH;
                res_value_next = '0;
                res_last_next  = 1'b1;
            end
            PH_EXT_SIZE:  res_kind_next = RK_EXT_SIZE;
            PH_EXT_BYTES: res_kind_next = RK_EXT_BYTE;
            PH_PAY_SIZE:
            begin
                res_kind_next = RK_PAY_SIZE;
                res_last_next = (word == 32'd0);
            end
            PH_PAY_BYTES:
            begin
                res_kind_next = RK_PAY_BYTE;
                res_last_next = (rem_dec == 32'd0);
            end
            default: ;
        endcase

        if (res_fire)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_skip_reg   <= HEADER_SKIP_RESET;
            magic_word_reg    <= MAGIC_WORD_RESET;
            magic_length_reg  <= MAGIC_LENGTH_RESET;
            phase_reg         <= PH_HEADER;
            header_count_reg  <= '0;
            bit_shift_reg     <= '0;
            bit_count_reg     <= '0;
            magic_index_reg   <= '0;
            bytes_rem_reg     <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            header_skip_reg   <= header_skip_next;
            magic_word_reg    <= magic_word_next;
            magic_length_reg  <= magic_length_next;
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            bit_shift_reg     <= bit_shift_next;
            bit_count_reg     <= bit_count_next;
            magic_index_reg   <= magic_index_next;
            bytes_rem_reg     <= bytes_rem_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            res_kind_reg  <= res_kind_next;
            res_value_reg <= res_value_next;
            res_last_reg  <= res_last_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = res_kind_reg;
    assign value        = res_value_reg;
    assign last         = res_last_reg;

    `ASSERT_IMPLIES(a_done_no_partial, clk, rst_n, phase_reg == PH_DONE, bit_count_reg == 6'd0)
    `ASSERT_IMPLIES(a_byte_count_range, clk, rst_n,
        phase_reg == PH_MAGIC || phase_reg == PH_EXT_BYTES || phase_reg == PH_PAY_BYTES,
        bit_count_reg < BYTE_BITS)
    `ASSERT_IMPLIES(a_bytes_pending, clk, rst_n,
        phase_reg == PH_EXT_BYTES || phase_reg == PH_PAY_BYTES, bytes_rem_reg != 32'd0)
    `ASSERT_NEXT(a_restart_clears, clk, rst_n, restart,
        phase_reg == PH_HEADER && header_count_reg == 16'd0 && bit_count_reg == 6'd0)

endmodule
